// File: rtl/pee_pkg.sv
package pee_pkg;

  // Default sizing of the value stack
  localparam int DEF_STACK_DEPTH = 16;
  localparam int DEF_VALUE_WIDTH = 32;

  // Width of the value field on the result stream
  localparam int OUT_WIDTH = 32;

  // Input symbol codes
  localparam logic [7:0] SYM_ADD  = 8'h2B;
  localparam logic [7:0] SYM_SUB  = 8'h2D;
  localparam logic [7:0] SYM_MUL  = 8'h2A;
  localparam logic [7:0] SYM_DIV  = 8'h2F;
  localparam logic [7:0] SYM_ZERO = 8'h30;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;
  localparam logic [1:0] ST_DIVZERO   = 2'd3;

  // Request to the serial multiply/divide unit
  typedef struct packed {
    logic start;
    logic is_div;
  } alu_req_t;

endpackage

// File: rtl/postfix_expression_evaluator.sv
// Postfix expression evaluator. Send one expression character per transfer on
// s_axis; mark the final character with tlast. A digit is any symbol other
// than + - * /. For + and - the left operand is read from the stack memory
// and the right operand is held in a top-of-stack register; * and / run in
// the bit-serial multiply/divide unit, and a divide by zero ends without it.
// After the final character the result is formed in a done state, which
// holds while the previous result still waits in the output register. The
// result leaves on m_axis as the 32-bit value with the status in tuser (0 ok,
// 1 underflow, 2 overflow, 3 division by zero); on error the value is 0. An
// error is sticky until the end of the expression, and the stack is emptied
// after each result.
module postfix_expression_evaluator #(
  parameter int STACK_DEPTH = pee_pkg::DEF_STACK_DEPTH,
  parameter int VALUE_WIDTH = pee_pkg::DEF_VALUE_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] symbol
  input  logic                          s_axis_tlast,  // last
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [pee_pkg::OUT_WIDTH-1:0] m_axis_tdata,  // [31:0] value
  output logic [1:0]                    m_axis_tuser   // [1:0] status
);

  localparam int IDX_W = $clog2(STACK_DEPTH);
  localparam int SP_W  = $clog2(STACK_DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_OPND = 2'd1;
  localparam logic [1:0] S_ALU  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]             state;
  logic [SP_W-1:0]        sp;
  logic [1:0]             err;
  logic [VALUE_WIDTH-1:0] tos;
  logic [7:0]             op_sym;
  logic                   last_pend;

  logic                   accept;
  logic                   is_op;
  logic [8:0]             push9;
  logic [VALUE_WIDTH-1:0] push_val;
  logic                   push_en;
  logic [SP_W-1:0]        sp_m2;
  logic                   sp_full;
  logic                   sp_short;

  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  logic [VALUE_WIDTH-1:0] ram_wdata;
  logic                   ram_re;
  logic [VALUE_WIDTH-1:0] ram_rdata;

  pee_pkg::alu_req_t      alu_req;
  logic                   alu_done;
  logic [VALUE_WIDTH-1:0] alu_result;

  logic                   wb_en;
  logic [VALUE_WIDTH-1:0] wb_val;
  logic                   out_load;
  logic [1:0]             fin_status;

  // Decode the incoming symbol
  always_comb begin
    accept   = s_axis_tvalid && s_axis_tready;
    is_op    = s_axis_tdata inside {pee_pkg::SYM_ADD, pee_pkg::SYM_SUB,
                                    pee_pkg::SYM_MUL, pee_pkg::SYM_DIV};
    push9    = {1'b0, s_axis_tdata} - {1'b0, pee_pkg::SYM_ZERO};
    push_val = VALUE_WIDTH'($signed(push9));
    sp_m2    = sp - SP_W'(2);
    sp_full  = (sp == SP_W'(STACK_DEPTH));
    sp_short = (sp < SP_W'(2));
    push_en  = accept && (err == pee_pkg::ST_OK) && !is_op && !sp_full;
  end

  // Result write-back for operators: left operand from memory, right from tos
  always_comb begin
    wb_en  = 1'b0;
    wb_val = alu_result;
    if (state == S_OPND) begin
      if (op_sym == pee_pkg::SYM_ADD) begin
        wb_en  = 1'b1;
        wb_val = ram_rdata + tos;
      end else if (op_sym == pee_pkg::SYM_SUB) begin
        wb_en  = 1'b1;
        wb_val = ram_rdata - tos;
      end
    end else if (alu_done) begin
      wb_en = 1'b1;
    end
  end

  // Stack memory ports
  always_comb begin
    ram_we    = push_en || wb_en;
    ram_waddr = push_en ? sp[IDX_W-1:0] : sp_m2[IDX_W-1:0];
    ram_wdata = push_en ? push_val : wb_val;
    ram_re    = accept && (err == pee_pkg::ST_OK) && is_op && !sp_short;
  end

  // Start the serial unit for multiply, or divide by a nonzero value
  always_comb begin
    alu_req.is_div = (op_sym == pee_pkg::SYM_DIV);
    alu_req.start  = (state == S_OPND) &&
                     ((op_sym == pee_pkg::SYM_MUL) ||
                      ((op_sym == pee_pkg::SYM_DIV) && (tos != '0)));
  end

  // Final status and result slot
  always_comb begin
    s_axis_tready = (state == S_IDLE);
    out_load      = (state == S_DONE) && (!m_axis_tvalid || m_axis_tready);
    fin_status    = err;
    if ((err == pee_pkg::ST_OK) && (sp == '0)) begin
      fin_status = pee_pkg::ST_UNDERFLOW;
    end
  end

  pee_stack_ram #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (VALUE_WIDTH),
    .IDX_W (IDX_W)
  ) u_stack (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (sp_m2[IDX_W-1:0]),
    .rd_data (ram_rdata)
  );

  pee_alu #(
    .WIDTH (VALUE_WIDTH)
  ) u_alu (
    .clk    (clk),
    .rst    (rst),
    .req    (alu_req),
    .opa    (ram_rdata),
    .opb    (tos),
    .done   (alu_done),
    .result (alu_result)
  );

  // Sequencer, stack pointer and sticky error
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sp        <= '0;
      err       <= pee_pkg::ST_OK;
      last_pend <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            last_pend <= s_axis_tlast;
            op_sym    <= s_axis_tdata;
            if (s_axis_tlast) begin
              state <= S_DONE;
            end
            if (err == pee_pkg::ST_OK) begin
              if (is_op) begin
                if (sp_short) begin
                  err <= pee_pkg::ST_UNDERFLOW;
                end else begin
                  state <= S_OPND;
                end
              end else if (sp_full) begin
                err <= pee_pkg::ST_OVERFLOW;
              end else begin
                tos <= push_val;
                sp  <= sp + 1'b1;
              end
            end
          end
        end
        S_OPND: begin
          if (wb_en) begin
            tos   <= wb_val;
            sp    <= sp - 1'b1;
            state <= last_pend ? S_DONE : S_IDLE;
          end else if (alu_req.start) begin
            state <= S_ALU;
          end else begin
            // divide by zero
            err   <= pee_pkg::ST_DIVZERO;
            sp    <= sp_m2;
            state <= last_pend ? S_DONE : S_IDLE;
          end
        end
        S_ALU: begin
          if (alu_done) begin
            tos   <= wb_val;
            sp    <= sp - 1'b1;
            state <= last_pend ? S_DONE : S_IDLE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            sp    <= '0;
            err   <= pee_pkg::ST_OK;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register: hold until the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tuser <= fin_status;
      if (fin_status == pee_pkg::ST_OK) begin
        m_axis_tdata <= pee_pkg::OUT_WIDTH'($signed(tos));
      end else begin
        m_axis_tdata <= '0;
      end
    end
  end

  // The stack pointer never passes the stack depth
  assert property (@(posedge clk) disable iff (rst)
    sp <= SP_W'(STACK_DEPTH))
    else $error("stack pointer beyond depth");

  // The serial unit finishes only while the sequencer waits for it
  assert property (@(posedge clk) disable iff (rst)
    alu_done |-> (state == S_ALU))
    else $error("serial unit done outside its wait state");

  // An error result carries a zero value
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser != pee_pkg::ST_OK)) |-> (m_axis_tdata == '0))
    else $error("nonzero value with error status");

  // A loaded result appears on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    out_load |=> m_axis_tvalid)
    else $error("result not presented");

endmodule

// File: rtl/pee_stack_ram.sv
module pee_stack_ram #(
  parameter int DEPTH = pee_pkg::DEF_STACK_DEPTH,
  parameter int WIDTH = pee_pkg::DEF_VALUE_WIDTH,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/pee_alu.sv
module pee_alu #(
  parameter int WIDTH = pee_pkg::DEF_VALUE_WIDTH
) (
  input  logic               clk,
  input  logic               rst,
  input  pee_pkg::alu_req_t  req,
  input  logic [WIDTH-1:0]   opa,
  input  logic [WIDTH-1:0]   opb,
  output logic               done,
  output logic [WIDTH-1:0]   result
);

  localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  logic             busy;
  logic             is_div;
  logic             neg;
  logic [CNT_W-1:0] cnt;
  logic [WIDTH:0]   acc;     // product accumulator or partial remainder
  logic [WIDTH-1:0] sreg;    // multiplier bits or dividend/quotient
  logic [WIDTH-1:0] oper;    // shifting multiplicand or divisor magnitude

  logic [WIDTH-1:0] mag_a;
  logic [WIDTH-1:0] mag_b;
  logic [WIDTH:0]   rem_sh;
  logic [WIDTH:0]   rem_sub;

  always_comb begin
    mag_a   = opa[WIDTH-1] ? (~opa + 1'b1) : opa;
    mag_b   = opb[WIDTH-1] ? (~opb + 1'b1) : opb;
    rem_sh  = {acc[WIDTH-1:0], sreg[WIDTH-1]};
    rem_sub = rem_sh - {1'b0, oper};
  end

  // One bit per cycle: shift-add multiply or restoring divide
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy   <= 1'b1;
        cnt    <= '0;
        is_div <= req.is_div;
        neg    <= opa[WIDTH-1] ^ opb[WIDTH-1];
        acc    <= '0;
        sreg   <= req.is_div ? mag_a : opb;
        oper   <= req.is_div ? mag_b : opa;
      end else if (busy) begin
        if (is_div) begin
          if (!rem_sub[WIDTH]) begin
            acc  <= rem_sub;
            sreg <= {sreg[WIDTH-2:0], 1'b1};
          end else begin
            acc  <= rem_sh;
            sreg <= {sreg[WIDTH-2:0], 1'b0};
          end
        end else begin
          if (sreg[0]) begin
            acc <= {1'b0, acc[WIDTH-1:0] + oper};
          end
          sreg <= sreg >> 1;
          oper <= oper << 1;
        end
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(WIDTH - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Apply the quotient sign after the last step
  always_comb begin
    if (is_div) begin
      result = neg ? (~sreg + 1'b1) : sreg;
    end else begin
      result = acc[WIDTH-1:0];
    end
  end

endmodule
